/* hw/rtl/twdp_pkg.sv */
// Shared types and constants for the ternary-weight dot product.
// Used by twdp_lane, twdp_merge and ternary_weight_dot_product; no dependencies.
package twdp_pkg;

    localparam int PHYS_LANES    = 8;
    localparam int LANES_DEFAULT = 8;
    localparam int ACT_W         = 8;
    localparam int CODE_W        = 2;
    localparam int TERM_W        = ACT_W + 1;
    localparam int ACTS_W        = PHYS_LANES * ACT_W;
    localparam int CODES_W       = PHYS_LANES * CODE_W;
    localparam int SUM_W         = 24;

    localparam logic signed [SUM_W-1:0] SUM_MAX = 24'sd4194304;
    localparam logic signed [SUM_W-1:0] SUM_MIN = -24'sd4194304;

    localparam logic [CODE_W-1:0] CODE_ZERO = 2'b00;
    localparam logic [CODE_W-1:0] CODE_PLUS = 2'b01;

    typedef struct packed {
        logic valid;
        logic last;
    } stage_ctrl_t;

endpackage

/* hw/rtl/twdp_lane.sv */
// One lane: selects the negated, plain or zero activation by its ternary code.
// Depends on twdp_pkg.
module twdp_lane (
    input  logic                                aclk,
    input  logic                                load,
    input  logic        [twdp_pkg::ACT_W-1:0]   act,
    input  logic        [twdp_pkg::CODE_W-1:0]  code,
    output logic signed [twdp_pkg::TERM_W-1:0]  term
);

    logic signed [twdp_pkg::TERM_W-1:0] act_ext;
    logic signed [twdp_pkg::TERM_W-1:0] term_next;
    logic signed [twdp_pkg::TERM_W-1:0] term_reg;

    assign act_ext = twdp_pkg::TERM_W'($signed(act));

    always_comb begin
        case (code)
            twdp_pkg::CODE_ZERO: begin
                term_next = '0;
            end
            twdp_pkg::CODE_PLUS: begin
                term_next = act_ext;
            end
            default: begin
                term_next = -act_ext;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            term_reg <= term_next;
        end
    end

    assign term = term_reg;

endmodule

/* hw/rtl/twdp_merge.sv */
// Merging stage: registered adder tree over the lane terms, then the row
// accumulator with saturation and the output register. Depends on twdp_pkg.
module twdp_merge #(
    parameter int NUM_LANES = twdp_pkg::PHYS_LANES
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  twdp_pkg::stage_ctrl_t               in_ctrl,
    input  logic signed [twdp_pkg::TERM_W-1:0]  terms [NUM_LANES],
    output logic                                in_ready,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic        [twdp_pkg::SUM_W-1:0]   out_sum
);

    localparam int TREE_W = $clog2(NUM_LANES * 128 + 1) + 1;

    logic signed [TREE_W-1:0]          tree_sum;
    twdp_pkg::stage_ctrl_t             b_ctrl_reg;
    twdp_pkg::stage_ctrl_t             b_ctrl_next;
    logic signed [TREE_W-1:0]          b_sum_reg;
    logic                              b_ready;
    logic                              c_accept;
    logic signed [twdp_pkg::SUM_W-1:0] acc;
    logic signed [twdp_pkg::SUM_W-1:0] acc_sat;
    logic signed [twdp_pkg::SUM_W-1:0] partial_reg;
    logic signed [twdp_pkg::SUM_W-1:0] partial_next;
    logic                              out_valid_reg;
    logic                              out_valid_next;
    logic        [twdp_pkg::SUM_W-1:0] out_sum_reg;

    always_comb begin
        tree_sum = '0;
        for (int i = 0; i < NUM_LANES; i++) begin
            tree_sum = tree_sum + TREE_W'(terms[i]);
        end
    end

    assign c_accept = b_ctrl_reg.valid && (!b_ctrl_reg.last || !out_valid_reg || out_ready);
    assign b_ready  = !b_ctrl_reg.valid || c_accept;
    assign in_ready = b_ready;

    always_comb begin
        b_ctrl_next = b_ctrl_reg;
        if (b_ready) begin
            b_ctrl_next = in_ctrl;
        end
    end

    assign acc = partial_reg + twdp_pkg::SUM_W'(b_sum_reg);

    always_comb begin
        if (acc > twdp_pkg::SUM_MAX) begin
            acc_sat = twdp_pkg::SUM_MAX;
        end else if (acc < twdp_pkg::SUM_MIN) begin
            acc_sat = twdp_pkg::SUM_MIN;
        end else begin
            acc_sat = acc;
        end
    end

    always_comb begin
        partial_next   = partial_reg;
        out_valid_next = out_valid_reg;
        if (out_ready) begin
            out_valid_next = 1'b0;
        end
        if (c_accept) begin
            if (b_ctrl_reg.last) begin
                partial_next   = '0;
                out_valid_next = 1'b1;
            end else begin
                partial_next = acc_sat;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_ctrl_reg    <= '0;
            partial_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            b_ctrl_reg    <= b_ctrl_next;
            partial_reg   <= partial_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (b_ready && in_ctrl.valid) begin
            b_sum_reg <= tree_sum;
        end
        if (c_accept && b_ctrl_reg.last) begin
            out_sum_reg <= acc_sat;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_sum   = out_sum_reg;

endmodule

/* hw/rtl/ternary_weight_dot_product.sv */
// Top level of the ternary-weight dot product: input stage, lanes and merge.
// Depends on twdp_pkg, twdp_lane and twdp_merge.
//
// Each input word carries eight int8 activations and eight 2-bit ternary codes;
// the block accepts one word per cycle and adds its terms into the running row
// sum. The word with tlast set passes the lane term, tree sum and output
// registers and produces one result word, holding the row sum clamped to
// -4194304 .. +4194304, after which the sum starts again from zero. The rate
// of one word per cycle is set by the accumulate-and-clamp loop in the merging
// stage. Words that do not end a row still flow while a result waits to be
// taken; only a row end behind a waiting result stalls the input.
module ternary_weight_dot_product #(
    parameter int LANES = twdp_pkg::LANES_DEFAULT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // activations [63:0], weight_codes [79:64]
    input  logic [twdp_pkg::ACTS_W+twdp_pkg::CODES_W-1:0] s_tdata,
    input  logic                           s_tlast,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // row_sum [23:0]
    output logic [twdp_pkg::SUM_W-1:0]     m_tdata
);

    localparam int ACT_LANES = (LANES > twdp_pkg::PHYS_LANES) ? twdp_pkg::PHYS_LANES : LANES;

    logic                               s_accept;
    logic                               b_ready;
    twdp_pkg::stage_ctrl_t              a_ctrl_reg;
    twdp_pkg::stage_ctrl_t              a_ctrl_next;
    logic signed [twdp_pkg::TERM_W-1:0] terms [ACT_LANES];

    assign s_tready = !a_ctrl_reg.valid || b_ready;
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        a_ctrl_next = a_ctrl_reg;
        if (s_accept) begin
            a_ctrl_next.valid = 1'b1;
            a_ctrl_next.last  = s_tlast;
        end else if (b_ready) begin
            a_ctrl_next.valid = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_ctrl_reg <= '0;
        end else begin
            a_ctrl_reg <= a_ctrl_next;
        end
    end

    for (genvar g = 0; g < ACT_LANES; g++) begin : g_lane
        twdp_lane u_lane (
            .aclk (aclk),
            .load (s_accept),
            .act  (s_tdata[g*twdp_pkg::ACT_W +: twdp_pkg::ACT_W]),
            .code (s_tdata[twdp_pkg::ACTS_W + g*twdp_pkg::CODE_W +: twdp_pkg::CODE_W]),
            .term (terms[g])
        );
    end

    twdp_merge #(
        .NUM_LANES (ACT_LANES)
    ) u_merge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_ctrl   (a_ctrl_reg),
        .terms     (terms),
        .in_ready  (b_ready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_sum   (m_tdata)
    );

    a_sum_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata) <= twdp_pkg::SUM_MAX
                      && $signed(m_tdata) >= twdp_pkg::SUM_MIN))
        else $error("row sum outside the saturation range");

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (a_ctrl_reg.valid && m_tvalid && !m_tready))
        else $error("input stalled without a waiting result");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> (!m_tvalid && s_tready))
        else $error("pipeline not empty after reset");

endmodule

/* sim/ternary_weight_dot_product_test.sv */
// Self-checking testbench for the ternary-weight dot product block.
// Drives rows of activation/weight words, predicts each row sum in the bench
// and compares results word by word. Needs twdp_pkg and the block's RTL only.
module ternary_weight_dot_product_test;
    timeunit 1ns;
    timeprecision 1ps;

    import twdp_pkg::*;

    localparam logic [CODE_W-1:0] CODE_MINUS     = 2'b10;
    localparam logic [CODE_W-1:0] CODE_MINUS_ALT = 2'b11;
    localparam int RANDOM_WORDS  = 1720;
    localparam int IDLE_PERCENT  = 18;
    localparam int MAX_REPORTS   = 10;

    typedef struct packed {
        logic [CODES_W-1:0] codes;
        logic [ACTS_W-1:0]  acts;
        logic               last;
    } row_word_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [ACTS_W+CODES_W-1:0] s_tdata = '0;
    logic s_tlast = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [SUM_W-1:0] m_tdata;

    row_word_t pending_words[$];
    logic [SUM_W-1:0] expected_row_sums[$];
    logic signed [SUM_W-1:0] row_accum = '0;
    bit word_taken = 1'b0;
    int words_accepted = 0;
    int rows_checked = 0;
    int errors = 0;

    ternary_weight_dot_product uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 aclk = ~aclk;

    function automatic int ternary_terms(logic [ACTS_W-1:0] acts, logic [CODES_W-1:0] codes);
        int acc;
        logic signed [ACT_W-1:0] act;
        logic [CODE_W-1:0] code;
        acc = 0;
        for (int lane = 0; lane < PHYS_LANES; lane++) begin
            act  = acts[lane*ACT_W +: ACT_W];
            code = codes[lane*CODE_W +: CODE_W];
            if (code[1]) begin
                acc -= act;
            end else if (code == CODE_PLUS) begin
                acc += act;
            end
        end
        return acc;
    endfunction

    // A quiet stretch in the middle of the random rows keeps both sides busy.
    function automatic bit take_break();
        if (words_accepted >= 600 && words_accepted < 1100) begin
            return 1'b0;
        end
        return $urandom_range(0, 99) < IDLE_PERCENT;
    endfunction

    task automatic add_word(logic [ACTS_W-1:0] acts, logic [CODES_W-1:0] codes, logic last);
        row_word_t w;
        w.acts  = acts;
        w.codes = codes;
        w.last  = last;
        pending_words.push_back(w);
    endtask

    always @(posedge aclk) begin
        int next_sum;
        if (aresetn && s_tvalid && s_tready) begin
            next_sum = int'(row_accum) + ternary_terms(s_tdata[ACTS_W-1:0],
                                                       s_tdata[ACTS_W +: CODES_W]);
            if (next_sum > int'(SUM_MAX)) begin
                next_sum = int'(SUM_MAX);
            end else if (next_sum < int'(SUM_MIN)) begin
                next_sum = int'(SUM_MIN);
            end
            if (s_tlast) begin
                expected_row_sums.push_back(next_sum[SUM_W-1:0]);
                row_accum = '0;
            end else begin
                row_accum = next_sum[SUM_W-1:0];
            end
            words_accepted++;
            word_taken = 1'b1;
        end
    end

    always @(negedge aclk) begin
        row_word_t w;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || word_taken) begin
            if (pending_words.size() != 0 && !take_break()) begin
                w = pending_words.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {w.codes, w.acts};
                s_tlast  <= w.last;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
        word_taken = 1'b0;
        m_tready <= !take_break();
    end

    always @(posedge aclk) begin
        logic [SUM_W-1:0] want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_row_sums.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS) begin
                    $display("%0t: unexpected row sum %0d", $realtime, $signed(m_tdata));
                end
            end else begin
                want = expected_row_sums.pop_front();
                rows_checked++;
                if (m_tdata !== want) begin
                    errors++;
                    if (errors <= MAX_REPORTS) begin
                        $display("%0t: row %0d sum expected %0d, got %0d", $realtime,
                                 rows_checked, $signed(want), $signed(m_tdata));
                    end
                end
            end
        end
    end

    initial begin
        int random_words;
        int row_len;
        logic [ACTS_W-1:0] acts;

        add_word({8{8'h7f}}, {8{CODE_PLUS}}, 1'b1);
        add_word({8{8'h80}}, {8{CODE_PLUS}}, 1'b1);
        add_word({8{8'h80}}, {8{CODE_MINUS}}, 1'b1);
        add_word({8{8'h80}}, {8{CODE_MINUS_ALT}}, 1'b1);
        add_word({8{8'h7f}}, {8{CODE_MINUS}}, 1'b1);
        add_word({8{8'hff}}, {8{CODE_ZERO}}, 1'b1);
        add_word({8{8'h00}}, 16'hffff, 1'b1);
        add_word(64'h80_7f_ff_01_80_7f_00_81,
                 {CODE_MINUS_ALT, CODE_MINUS, CODE_PLUS, CODE_ZERO,
                  CODE_PLUS, CODE_MINUS_ALT, CODE_PLUS, CODE_MINUS}, 1'b0);
        add_word({8{8'h80}}, {8{CODE_MINUS_ALT}}, 1'b0);
        add_word(64'hffff_ffff_ffff_ffff, 16'h5555, 1'b1);
        for (int k = 0; k < 6; k++) begin
            add_word({8{8'h7f}}, {8{CODE_PLUS}}, k == 5);
        end
        add_word({8{8'h80}}, {8{CODE_PLUS}}, 1'b0);
        add_word({8{8'h7f}}, {8{CODE_MINUS}}, 1'b0);
        add_word(64'h0123_4567_89ab_cdef, 16'haaaa, 1'b1);

        random_words = 0;
        while (random_words < RANDOM_WORDS) begin
            row_len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 64)
                                                  : $urandom_range(1, 12);
            for (int k = 0; k < row_len; k++) begin
                if ($urandom_range(0, 3) == 0) begin
                    for (int lane = 0; lane < PHYS_LANES; lane++) begin
                        case ($urandom_range(0, 3))
                            0: acts[lane*ACT_W +: ACT_W] = 8'h80;
                            1: acts[lane*ACT_W +: ACT_W] = 8'h7f;
                            2: acts[lane*ACT_W +: ACT_W] = 8'hff;
                            default: acts[lane*ACT_W +: ACT_W] = 8'h00;
                        endcase
                    end
                end else begin
                    acts = {$urandom, $urandom};
                end
                add_word(acts, CODES_W'($urandom_range(0, 65535)), k == row_len - 1);
            end
            random_words += row_len;
        end

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        while (pending_words.size() != 0 || s_tvalid) begin
            @(posedge aclk);
        end
        while (expected_row_sums.size() != 0) begin
            @(posedge aclk);
        end
        repeat (10) @(posedge aclk);

        $display("Sent %0d words and checked %0d row sums, with short and long rows",
                 words_accepted, rows_checked);
        $display("and extreme activations under random stalls on both sides.");
        if (errors == 0 && expected_row_sums.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("Run did not finish in time.");
        $display("*** FAILED ***");
        $finish;
    end

endmodule

/* files.f */
hw/rtl/twdp_pkg.sv
hw/rtl/twdp_lane.sv
hw/rtl/twdp_merge.sv
hw/rtl/ternary_weight_dot_product.sv
sim/ternary_weight_dot_product_test.sv
